// File: rtl/rbnh_pkg.sv
// ----------------------------------------------------------------------------
// rbnh_pkg
// Types and constants shared by the ray/box nearest-hit block.
// ----------------------------------------------------------------------------
package rbnh_pkg;

   localparam int IDX_W       = 10;   // width of nearest_index
   localparam int DIST_W      = 31;   // width of nearest_distance
   localparam int NUM_W       = 33;   // bound minus origin
   localparam int DIV_STEPS   = 49;   // quotient bits of (diff << 16) / d
   localparam int DIV_CNT_W   = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam logic signed [31:0] DIST_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] DIST_MIN = 32'sh8000_0000;

   typedef logic [2:0][31:0] vec3_type;

   typedef enum logic [2:0] {
      REG_ORIGIN_X    = 3'd0,
      REG_ORIGIN_Y    = 3'd1,
      REG_ORIGIN_Z    = 3'd2,
      REG_DIRECTION_X = 3'd3,
      REG_DIRECTION_Y = 3'd4,
      REG_DIRECTION_Z = 3'd5
   } csr_idx_type;

   // one classified box, front to back
   typedef struct packed {
      logic [2:0][NUM_W-1:0] num_lo;     // box_min - origin, signed
      logic [2:0][NUM_W-1:0] num_hi;     // box_max - origin, signed
      logic [2:0]            parallel;   // direction is zero on that axis
      logic [2:0]            par_pass;   // origin within bounds on that axis
      logic                  skip;       // past the index limit
      logic                  last;
      logic [IDX_W-1:0]      position;
   } box_entry_type;

   typedef struct packed {
      logic                    start;
      logic signed [NUM_W-1:0] num;
      logic signed [31:0]      den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] quot;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AXIS,
      ST_DIV_LO,
      ST_DIV_HI,
      ST_CHECK,
      ST_FINISH
   } back_state_type;

endpackage

// File: rtl/rbnh_queue.sv
// ----------------------------------------------------------------------------
// rbnh_queue
// Short FIFO of classified boxes between the front and the back.
// ----------------------------------------------------------------------------
module rbnh_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rbnh_pkg::box_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output rbnh_pkg::box_entry_type head,
   output logic                   not_empty
);
   import rbnh_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   box_entry_type      mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/rbnh_front.sv
// ----------------------------------------------------------------------------
// rbnh_front
// Takes boxes, numbers them, and works out the per-axis differences and
// parallel-axis tests before handing them to the queue.
// ----------------------------------------------------------------------------
module rbnh_front #(
   parameter int MAX_BOXES = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [191:0]            req_tdata,
   input  logic                    req_tlast,
   input  rbnh_pkg::vec3_type      origin,
   input  rbnh_pkg::vec3_type      direction,
   input  logic                    q_full,
   output logic                    push,
   output rbnh_pkg::box_entry_type push_entry
);
   import rbnh_pkg::*;

   localparam int CNT_W = $clog2(MAX_BOXES + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             skip;

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;
   assign skip       = (count_ff >= CNT_W'(MAX_BOXES));

   always_comb begin
      logic signed [31:0] lo, hi, o;
      push_entry = '0;
      for (int i = 0; i < 3; i++) begin
         lo = $signed(req_tdata[32*i +: 32]);
         hi = $signed(req_tdata[96 + 32*i +: 32]);
         o  = $signed(origin[i]);
         push_entry.num_lo[i]   = {lo[31], lo} - {o[31], o};
         push_entry.num_hi[i]   = {hi[31], hi} - {o[31], o};
         push_entry.parallel[i] = (direction[i] == '0);
         push_entry.par_pass[i] = (o >= lo) && (o <= hi);
      end
      push_entry.skip     = skip;
      push_entry.last     = req_tlast;
      push_entry.position = IDX_W'(count_ff);
   end

   always_comb begin
      count_in = count_ff;
      if (push) begin
         if (req_tlast) begin
            count_in = '0;
         end else if (!skip) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/rbnh_div.sv
// ----------------------------------------------------------------------------
// rbnh_div
// Signed (num << 16) / den, truncated and saturated to 32 bits.
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbnh_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rbnh_pkg::div_req_type req,
   output rbnh_pkg::div_rsp_type rsp
);
   import rbnh_pkg::*;

   localparam int Q_W = DIV_STEPS;

   logic                 busy_ff, fin_ff, done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [Q_W-1:0]       q_ff;
   logic [31:0]          rem_ff;
   logic [31:0]          den_ff;
   logic                 neg_ff;
   logic signed [31:0]   quot_ff;

   logic [NUM_W-1:0]     num_mag;
   logic [31:0]          den_mag;
   logic [32:0]          shifted, trial;
   logic signed [31:0]   sat;

   assign num_mag = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
   assign den_mag = req.den[31] ? 32'(-req.den) : 32'(req.den);
   assign shifted = {rem_ff, q_ff[Q_W-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      if (neg_ff) begin
         sat = (q_ff > Q_W'(33'h0_8000_0000)) ? DIST_MIN : -$signed(q_ff[31:0]);
      end else begin
         sat = (q_ff > Q_W'(33'h0_7FFF_FFFF)) ? DIST_MAX : $signed(q_ff[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         q_ff   <= {num_mag, 16'd0};
         rem_ff <= '0;
         den_ff <= den_mag;
         neg_ff <= req.num[NUM_W-1] ^ req.den[31];
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            q_ff   <= {q_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[31:0];
            q_ff   <= {q_ff[Q_W-2:0], 1'b0};
         end
      end
      if (fin_ff) begin
         quot_ff <= sat;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

// File: rtl/rbnh_back.sv
// ----------------------------------------------------------------------------
// rbnh_back
// Runs the slab test of one queued box axis by axis on the shared divider,
// keeps the running nearest hit and registers the pick result.
// ----------------------------------------------------------------------------
module rbnh_back (
   input  logic                    clock,
   input  logic                    reset,
   input  rbnh_pkg::vec3_type      direction,
   input  rbnh_pkg::box_entry_type head,
   input  logic                    not_empty,
   output logic                    pop,
   output rbnh_pkg::div_req_type   div_req,
   input  rbnh_pkg::div_rsp_type   div_rsp,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [47:0]             rsp_tdata
);
   import rbnh_pkg::*;

   back_state_type     state_ff, state_in;
   box_entry_type      entry_ff, entry_in;
   logic [1:0]         axis_ff, axis_in;
   logic signed [31:0] tmin_ff, tmin_in, tmax_ff, tmax_in, ta_ff, ta_in;
   logic               hit_ff, hit_in;
   logic [DIST_W-1:0]  best_ff, best_in;
   logic [IDX_W-1:0]   best_pos_ff, best_pos_in;
   logic               any_ff, any_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_hit_ff, out_hit_in;
   logic [IDX_W-1:0]   out_idx_ff, out_idx_in;
   logic [DIST_W-1:0]  out_dist_ff, out_dist_in;

   logic signed [31:0] near_t, far_t;
   logic               better;

   assign near_t = (ta_ff <= div_rsp.quot) ? ta_ff : div_rsp.quot;
   assign far_t  = (ta_ff <= div_rsp.quot) ? div_rsp.quot : ta_ff;
   assign better = hit_ff && (tmin_ff > 32'sd0) && (tmin_ff < $signed({1'b0, best_ff}));

   always_comb begin
      state_in     = state_ff;
      entry_in     = entry_ff;
      axis_in      = axis_ff;
      tmin_in      = tmin_ff;
      tmax_in      = tmax_ff;
      ta_in        = ta_ff;
      hit_in       = hit_ff;
      best_in      = best_ff;
      best_pos_in  = best_pos_ff;
      any_in       = any_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_hit_in   = out_hit_ff;
      out_idx_in   = out_idx_ff;
      out_dist_in  = out_dist_ff;
      pop          = 1'b0;
      div_req      = '0;
      div_req.num  = $signed(entry_ff.num_lo[axis_ff]);
      div_req.den  = $signed(direction[axis_ff]);

      unique case (state_ff)
         ST_IDLE: begin
            if (not_empty) begin
               pop      = 1'b1;
               entry_in = head;
               axis_in  = '0;
               tmin_in  = '0;
               tmax_in  = DIST_MAX;
               hit_in   = !head.skip;
               state_in = head.skip ? ST_FINISH : ST_AXIS;
            end
         end
         ST_AXIS: begin
            if (entry_ff.parallel[axis_ff]) begin
               if (!entry_ff.par_pass[axis_ff]) begin
                  hit_in   = 1'b0;
                  state_in = ST_FINISH;
               end else if (axis_ff == 2'd2) begin
                  state_in = ST_FINISH;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV_LO;
            end
         end
         ST_DIV_LO: begin
            if (div_rsp.done) begin
               ta_in         = div_rsp.quot;
               div_req.start = 1'b1;
               div_req.num   = $signed(entry_ff.num_hi[axis_ff]);
               state_in      = ST_DIV_HI;
            end
         end
         ST_DIV_HI: begin
            if (div_rsp.done) begin
               if (near_t > tmin_ff) tmin_in = near_t;
               if (far_t < tmax_ff)  tmax_in = far_t;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (tmin_ff > tmax_ff) begin
               hit_in   = 1'b0;
               state_in = ST_FINISH;
            end else if (axis_ff == 2'd2) begin
               state_in = ST_FINISH;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_AXIS;
            end
         end
         ST_FINISH: begin
            if (!entry_ff.last) begin
               if (better) begin
                  best_in     = DIST_W'(tmin_ff);
                  best_pos_in = entry_ff.position;
                  any_in      = 1'b1;
               end
               state_in = ST_IDLE;
            end else if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_hit_in   = any_ff || better;
               out_idx_in   = better ? entry_ff.position : (any_ff ? best_pos_ff : '0);
               out_dist_in  = better ? DIST_W'(tmin_ff) : best_ff;
               best_in      = DIST_W'(DIST_MAX);
               best_pos_in  = '0;
               any_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         best_ff      <= DIST_W'(DIST_MAX);
         best_pos_ff  <= '0;
         any_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         best_ff      <= best_in;
         best_pos_ff  <= best_pos_in;
         any_ff       <= any_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff    <= entry_in;
      axis_ff     <= axis_in;
      tmin_ff     <= tmin_in;
      tmax_ff     <= tmax_in;
      ta_ff       <= ta_in;
      hit_ff      <= hit_in;
      out_hit_ff  <= out_hit_in;
      out_idx_ff  <= out_idx_in;
      out_dist_ff <= out_dist_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_dist_ff, out_idx_ff, out_hit_ff};

endmodule

// File: rtl/ray_box_nearest_hit.sv
// ----------------------------------------------------------------------------
// ray_box_nearest_hit
// Nearest ray/box hit over a stream of axis-aligned boxes.
// ----------------------------------------------------------------------------
// The ray (origin, direction; signed Q16.16) must be written over the APB port
// only while the block is idle; the block itself does not enforce this. Boxes
// stream in on req_*; tlast closes a pick, and one result item then comes out
// on rsp_* with the nearest box hit at a distance above zero. Boxes are
// classified on entry and queued two deep; the back end runs the slab
// divisions on one shared restoring divider that makes one quotient bit per
// cycle. Boxes beyond MAX_BOXES are counted out. A last box waits in the back
// end while the previous result item is still held on rsp_*.
module ray_box_nearest_hit #(
   parameter int MAX_BOXES = 1024
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,
   input  logic         req_tlast,       // last_box
   // rsp_tdata: hit_found, nearest_index[9:0], nearest_distance[30:0], zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import rbnh_pkg::*;

   vec3_type      origin_ff, direction_ff;
   csr_idx_type   csr_idx;
   logic          csr_wr;
   logic          push, q_full, pop, not_empty;
   box_entry_type push_entry, head;
   div_req_type   div_req;
   div_rsp_type   div_rsp;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_idx_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff    <= '0;
         direction_ff <= {32'h0001_0000, 32'd0, 32'd0};
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ORIGIN_X:    origin_ff[0]    <= csr_pwdata;
            REG_ORIGIN_Y:    origin_ff[1]    <= csr_pwdata;
            REG_ORIGIN_Z:    origin_ff[2]    <= csr_pwdata;
            REG_DIRECTION_X: direction_ff[0] <= csr_pwdata;
            REG_DIRECTION_Y: direction_ff[1] <= csr_pwdata;
            REG_DIRECTION_Z: direction_ff[2] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ORIGIN_X:    csr_prdata = origin_ff[0];
         REG_ORIGIN_Y:    csr_prdata = origin_ff[1];
         REG_ORIGIN_Z:    csr_prdata = origin_ff[2];
         REG_DIRECTION_X: csr_prdata = direction_ff[0];
         REG_DIRECTION_Y: csr_prdata = direction_ff[1];
         REG_DIRECTION_Z: csr_prdata = direction_ff[2];
         default:         csr_prdata = '0;
      endcase
   end

   rbnh_front #(
      .MAX_BOXES(MAX_BOXES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .origin     (origin_ff),
      .direction  (direction_ff),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   rbnh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty)
   );

   rbnh_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   rbnh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .direction  (direction_ff),
      .head       (head),
      .not_empty  (not_empty),
      .pop        (pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
